### sv/asml_pkg.sv
// Shared types, character codes and mnemonic tables for the Hack line encoder.
package asml_pkg;

  // One character item as it travels from the input register to the parser
  typedef struct packed {
    logic [7:0] char_code;
    logic       is_compute_form;
    logic       last_char;
  } item_t;

  // Input register slot seen by the parser
  typedef struct packed {
    logic  valid;
    item_t item;
  } slot_t;

  // One encoded result
  typedef struct packed {
    logic [15:0] machine_word;
    logic        syntax_error;
  } result_t;

  // Parser to result register: load strobe with the word to hold
  typedef struct packed {
    logic    load;
    result_t result;
  } load_t;

  // Character codes
  localparam logic [7:0] CH_ZERO   = 8'd48;
  localparam logic [7:0] CH_NINE   = 8'd57;
  localparam logic [7:0] CH_EQUALS = 8'd61;
  localparam logic [7:0] CH_SEMI   = 8'd59;
  localparam logic [7:0] CH_LF     = 8'd10;
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_A      = 8'd65;
  localparam logic [7:0] CH_D      = 8'd68;
  localparam logic [7:0] CH_M      = 8'd77;
  localparam logic [7:0] CH_J      = 8'd74;

  // Field geometry
  localparam logic [1:0] FIELD_MAX = 2'd3;
  localparam int         COMP_NUM  = 28;
  localparam int         JUMP_NUM  = 7;

  // Field phases
  localparam logic [1:0] PH_DEST_COMP = 2'd0;
  localparam logic [1:0] PH_COMP      = 2'd1;
  localparam logic [1:0] PH_JUMP      = 2'd2;

  // Comp mnemonics: text (first character in the top byte), length, a+c1..c6 code
  localparam logic [23:0] COMP_TEXT [COMP_NUM] = '{
    {"0", 16'h0}, {"1", 16'h0}, {"-1", 8'h0},
    {"D", 16'h0}, {"A", 16'h0}, {"M", 16'h0},
    {"!D", 8'h0}, {"!A", 8'h0}, {"!M", 8'h0},
    {"-D", 8'h0}, {"-A", 8'h0}, {"-M", 8'h0},
    "D+1", "A+1", "M+1",
    "D-1", "A-1", "M-1",
    "D+A", "D+M",
    "D-A", "D-M",
    "A-D", "M-D",
    "D&A", "D&M",
    "D|A", "D|M"
  };

  localparam logic [1:0] COMP_LEN [COMP_NUM] = '{
    2'd1, 2'd1, 2'd2,
    2'd1, 2'd1, 2'd1,
    2'd2, 2'd2, 2'd2,
    2'd2, 2'd2, 2'd2,
    2'd3, 2'd3, 2'd3,
    2'd3, 2'd3, 2'd3,
    2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3
  };

  localparam logic [6:0] COMP_CODE [COMP_NUM] = '{
    7'h2A, 7'h3F, 7'h3A,
    7'h0C, 7'h30, 7'h70,
    7'h0D, 7'h31, 7'h71,
    7'h0F, 7'h33, 7'h73,
    7'h1F, 7'h37, 7'h77,
    7'h0E, 7'h32, 7'h72,
    7'h02, 7'h42,
    7'h13, 7'h53,
    7'h07, 7'h47,
    7'h00, 7'h40,
    7'h15, 7'h55
  };

  // Jump suffixes after the leading J, in code order JGT..JMP (codes 1..7)
  localparam logic [15:0] JUMP_TEXT [JUMP_NUM] = '{
    "GT", "EQ", "GE", "LT", "NE", "LE", "MP"
  };

endpackage

### sv/asml_in_if.sv
// Character channel: valid/ready handshake carrying one line character.
interface asml_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       is_compute_form;
  logic       last_char;

  modport source (output valid, output char_code, output is_compute_form,
                  output last_char, input ready);
  modport sink   (input valid, input char_code, input is_compute_form,
                  input last_char, output ready);
endinterface

### sv/asml_out_if.sv
// Word channel: valid/ready handshake carrying one encoded instruction.
interface asml_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] machine_word;
  logic        syntax_error;

  modport source (output valid, output machine_word, output syntax_error, input ready);
  modport sink   (input valid, input machine_word, input syntax_error, output ready);
endinterface

### sv/asml_in_stage.sv
// Input register: captures one character request and holds it until the parser takes it.
module asml_in_stage (
  input  logic                clk,
  input  logic                rst,
  asml_in_if.sink             chars,
  input  logic                advance,
  output asml_pkg::slot_t     slot
);

  logic               valid;
  asml_pkg::item_t    item;

  // Accept when empty or when the held request moves on this cycle
  assign chars.ready = !valid || advance;

  // Control: slot occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (chars.ready) begin
      valid <= chars.valid;
    end
  end

  // Payload: capture on acceptance
  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      item.char_code       <= chars.char_code;
      item.is_compute_form <= chars.is_compute_form;
      item.last_char       <= chars.last_char;
    end
  end

  assign slot.valid = valid;
  assign slot.item  = item;

endmodule

### sv/asml_parser.sv
// Line parser: folds each character into the line state and encodes the word on the last one.
module asml_parser (
  input  logic               clk,
  input  logic               rst,
  input  asml_pkg::slot_t    slot,
  input  logic               out_free,
  output logic               advance,
  output asml_pkg::load_t    load
);

  // Line state
  logic             started;          // a non line-end character has been seen
  logic [1:0]       field_phase;
  logic [14:0]      decimal_accumulator;
  logic [2:0]       dest_bits;
  logic             seen_equals;
  logic             seen_semicolon;
  logic [2:0][7:0]  comp_chars;
  logic [1:0]       comp_count;
  logic [2:0][7:0]  jump_chars;
  logic [1:0]       jump_count;
  logic             error_seen;

  logic             started_next;
  logic [1:0]       field_phase_next;
  logic [14:0]      decimal_accumulator_next;
  logic [2:0]       dest_bits_next;
  logic             seen_equals_next;
  logic             seen_semicolon_next;
  logic [2:0][7:0]  comp_chars_next;
  logic [1:0]       comp_count_next;
  logic [2:0][7:0]  jump_chars_next;
  logic [1:0]       jump_count_next;
  logic             error_seen_next;

  logic [7:0]       ch;
  logic             take;
  logic             is_digit;
  logic [14:0]      acc_times_ten;
  logic [3:0]       digit;
  logic [3:0]       dest_enc;
  logic [7:0]       comp_enc;
  logic [3:0]       jump_enc;

  // Dest field: any mix of A, D, M; empty or other characters are bad. Returns {bad, bits}.
  function automatic logic [3:0] enc_dest(input logic [2:0][7:0] chr, input logic [1:0] cnt);
    logic       bad;
    logic [2:0] bits;
    bad  = (cnt == 2'd0);
    bits = 3'b000;
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < cnt) begin
        if (chr[i] == asml_pkg::CH_A) begin
          bits[2] = 1'b1;
        end else if (chr[i] == asml_pkg::CH_D) begin
          bits[1] = 1'b1;
        end else if (chr[i] == asml_pkg::CH_M) begin
          bits[0] = 1'b1;
        end else begin
          bad = 1'b1;
        end
      end
    end
    return bad ? 4'b1000 : {1'b0, bits};
  endfunction

  // Comp field: exact match against the mnemonic table. Returns {bad, code}.
  function automatic logic [7:0] enc_comp(input logic [2:0][7:0] chr, input logic [1:0] cnt);
    logic       found;
    logic [6:0] code;
    logic [1:0] len;
    found = 1'b0;
    code  = 7'd0;
    for (int k = 0; k < asml_pkg::COMP_NUM; k++) begin
      len = asml_pkg::COMP_LEN[k];
      if ((len == cnt) &&
          (chr[0] == asml_pkg::COMP_TEXT[k][23:16]) &&
          (len < 2'd2 || chr[1] == asml_pkg::COMP_TEXT[k][15:8]) &&
          (len < 2'd3 || chr[2] == asml_pkg::COMP_TEXT[k][7:0])) begin
        found = 1'b1;
        code  = code | asml_pkg::COMP_CODE[k];
      end
    end
    return {!found, code};
  endfunction

  // Jump field: J followed by one of the seven suffixes. Returns {bad, bits}.
  function automatic logic [3:0] enc_jump(input logic [2:0][7:0] chr, input logic [1:0] cnt);
    logic       found;
    logic [2:0] bits;
    found = 1'b0;
    bits  = 3'd0;
    for (int k = 0; k < asml_pkg::JUMP_NUM; k++) begin
      if (cnt == asml_pkg::FIELD_MAX && chr[0] == asml_pkg::CH_J &&
          chr[1] == asml_pkg::JUMP_TEXT[k][15:8] && chr[2] == asml_pkg::JUMP_TEXT[k][7:0]) begin
        found = 1'b1;
        bits  = bits | 3'(k + 1);
      end
    end
    return {!found, bits};
  endfunction

  assign ch   = slot.item.char_code;
  // A non-last request always retires; the last one needs room in the result register
  assign advance = !slot.item.last_char || out_free;
  assign take    = slot.valid && advance;

  assign is_digit      = (ch >= asml_pkg::CH_ZERO) && (ch <= asml_pkg::CH_NINE);
  assign digit         = 4'(ch - asml_pkg::CH_ZERO);
  assign acc_times_ten = {decimal_accumulator[11:0], 3'b000} +
                         {decimal_accumulator[13:0], 1'b0};
  assign dest_enc      = enc_dest(comp_chars, comp_count);

  // Fold the current character into the line state
  always_comb begin
    started_next             = started;
    field_phase_next         = field_phase;
    decimal_accumulator_next = decimal_accumulator;
    dest_bits_next           = dest_bits;
    seen_equals_next         = seen_equals;
    seen_semicolon_next      = seen_semicolon;
    comp_chars_next          = comp_chars;
    comp_count_next          = comp_count;
    jump_chars_next          = jump_chars;
    jump_count_next          = jump_count;
    error_seen_next          = error_seen;

    if (ch != asml_pkg::CH_LF && ch != asml_pkg::CH_CR) begin
      started_next = 1'b1;
      if (!slot.item.is_compute_form) begin
        // Address form: skip the leading character, then decimal digits
        if (started) begin
          if (is_digit) begin
            decimal_accumulator_next = acc_times_ten + {11'd0, digit};
          end else begin
            error_seen_next = 1'b1;
          end
        end
      end else if (ch == asml_pkg::CH_EQUALS) begin
        // Close the dest field and restart the comp buffer
        if (field_phase == asml_pkg::PH_DEST_COMP && !seen_equals && !seen_semicolon) begin
          dest_bits_next   = dest_enc[2:0];
          error_seen_next  = error_seen | dest_enc[3];
          seen_equals_next = 1'b1;
          comp_chars_next  = '0;
          comp_count_next  = 2'd0;
          field_phase_next = asml_pkg::PH_COMP;
        end else begin
          error_seen_next = 1'b1;
        end
      end else if (ch == asml_pkg::CH_SEMI) begin
        if (!seen_semicolon) begin
          seen_semicolon_next = 1'b1;
          field_phase_next    = asml_pkg::PH_JUMP;
        end else begin
          error_seen_next = 1'b1;
        end
      end else if (field_phase == asml_pkg::PH_JUMP) begin
        // Over-long field: poison the buffer
        if (jump_count == asml_pkg::FIELD_MAX) begin
          jump_chars_next = '0;
          error_seen_next = 1'b1;
        end else begin
          jump_chars_next[jump_count] = ch;
          jump_count_next             = jump_count + 2'd1;
        end
      end else begin
        if (comp_count == asml_pkg::FIELD_MAX) begin
          comp_chars_next = '0;
          error_seen_next = 1'b1;
        end else begin
          comp_chars_next[comp_count] = ch;
          comp_count_next             = comp_count + 2'd1;
        end
      end
    end
  end

  // Encode the finished line from the updated state
  assign comp_enc = enc_comp(comp_chars_next, comp_count_next);
  assign jump_enc = seen_semicolon_next ? enc_jump(jump_chars_next, jump_count_next) : 4'd0;

  always_comb begin
    load.load = take && slot.item.last_char;
    if (!slot.item.is_compute_form) begin
      load.result.machine_word = error_seen_next ? 16'd0 : {1'b0, decimal_accumulator_next};
      load.result.syntax_error = error_seen_next;
    end else begin
      load.result.machine_word = {3'b111, comp_enc[6:0], dest_bits_next, jump_enc[2:0]};
      load.result.syntax_error = error_seen_next | comp_enc[7] | jump_enc[3];
    end
  end

  // Advance the line state; clear it once the word is handed on
  always_ff @(posedge clk) begin
    if (rst || (take && slot.item.last_char)) begin
      started             <= 1'b0;
      field_phase         <= asml_pkg::PH_DEST_COMP;
      decimal_accumulator <= 15'd0;
      dest_bits           <= 3'd0;
      seen_equals         <= 1'b0;
      seen_semicolon      <= 1'b0;
      comp_chars          <= '0;
      comp_count          <= 2'd0;
      jump_chars          <= '0;
      jump_count          <= 2'd0;
      error_seen          <= 1'b0;
    end else if (take) begin
      started             <= started_next;
      field_phase         <= field_phase_next;
      decimal_accumulator <= decimal_accumulator_next;
      dest_bits           <= dest_bits_next;
      seen_equals         <= seen_equals_next;
      seen_semicolon      <= seen_semicolon_next;
      comp_chars          <= comp_chars_next;
      comp_count          <= comp_count_next;
      jump_chars          <= jump_chars_next;
      jump_count          <= jump_count_next;
      error_seen          <= error_seen_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_load_needs_last: assert property (@(posedge clk) disable iff (rst)
    load.load |-> (slot.valid && slot.item.last_char && out_free))
    else $error("word loaded without a held last character");

  a_clear_after_word: assert property (@(posedge clk) disable iff (rst)
    load.load |=> (!started && !error_seen && comp_count == 2'd0 && jump_count == 2'd0))
    else $error("line state not cleared after a word");

  a_semi_phase: assert property (@(posedge clk) disable iff (rst)
    seen_semicolon == (field_phase == asml_pkg::PH_JUMP))
    else $error("jump phase and semicolon flag disagree");

  a_equals_phase: assert property (@(posedge clk) disable iff (rst)
    seen_equals |-> (field_phase != asml_pkg::PH_DEST_COMP))
    else $error("dest phase after an equals sign");
`endif

endmodule

### sv/asml_out_stage.sv
// Result register: holds one encoded word until the sink takes it.
module asml_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  asml_pkg::load_t   load,
  output logic              out_free,
  asml_out_if.source        words
);

  logic              valid;
  asml_pkg::result_t result;

  assign out_free = !valid || words.ready;

  // Control: occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load.load) begin
      valid <= 1'b1;
    end else if (words.ready) begin
      valid <= 1'b0;
    end
  end

  // Payload: capture the new word
  always_ff @(posedge clk) begin
    if (load.load) begin
      result <= load.result;
    end
  end

  assign words.valid        = valid;
  assign words.machine_word = result.machine_word;
  assign words.syntax_error = result.syntax_error;

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load.load |-> (!valid || words.ready))
    else $error("held word overwritten before it was taken");
`endif

endmodule

### sv/assembly_line_to_machine_word.sv
// Hack line encoder: one character request per cycle in, one instruction word per line out.
// Output path: the last character is held in the input register, then parsed and encoded
// into the result register, which offers the word; the load waits while that register
// still holds an untaken word.
// Throughput: one character per cycle; only a last character waits, and only while the
// result register still holds a word that the sink has not taken.
// Reset (synchronous, rst high) empties both registers and clears the line state.
module assembly_line_to_machine_word (
  input  logic        clk,
  input  logic        rst,
  asml_in_if.sink     chars,
  asml_out_if.source  words
);

  asml_pkg::slot_t slot;
  asml_pkg::load_t load;
  logic            advance;
  logic            out_free;

  asml_in_stage u_in_stage (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars),
    .advance (advance),
    .slot    (slot)
  );

  asml_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .slot     (slot),
    .out_free (out_free),
    .advance  (advance),
    .load     (load)
  );

  asml_out_stage u_out_stage (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .out_free (out_free),
    .words    (words)
  );

endmodule

### tb/line_encode_check.sv
`timescale 1ns / 100ps
// Watches both channels of the Hack line encoder, predicts each instruction word and compares.
module line_encode_check
  import asml_pkg::*;
(
  input  logic clk,
  input  logic rst,
  asml_in_if   chars,
  asml_out_if  words,
  output int   fail_count,
  output int   pending,
  output int   words_checked,
  output int   error_words
);

  // Line state of the predictor
  logic [7:0]  line_pos;
  logic [1:0]  phase;
  logic [14:0] dec_acc;
  logic [2:0]  dest_code;
  logic        have_equals;
  logic        have_semi;
  logic        line_err;
  logic [7:0]  comp_buf [3];
  logic [1:0]  comp_len;
  logic [7:0]  jump_buf [3];
  logic [1:0]  jump_len;

  result_t expected_words [$];
  result_t want;
  int      fails;
  int      checked;
  int      flagged;

  task automatic report_mismatch(input string what);
    fails++;
    $display("%0t encode_check: %s", $time, what);
  endtask

  function automatic void clear_line();
    line_pos    = '0;
    phase       = PH_DEST_COMP;
    dec_acc     = '0;
    dest_code   = '0;
    have_equals = 1'b0;
    have_semi   = 1'b0;
    line_err    = 1'b0;
    comp_buf    = '{default: '0};
    comp_len    = '0;
    jump_buf    = '{default: '0};
    jump_len    = '0;
  endfunction

  // Dest letters A, D, M in any order and with repeats; anything else gives zero bits
  function automatic logic [2:0] dest_of();
    logic [2:0] bits;
    bits = '0;
    if (comp_len == 0) begin
      line_err = 1'b1;
      return '0;
    end
    for (int i = 0; i < comp_len; i++) begin
      case (comp_buf[i])
        CH_A: bits |= 3'b100;
        CH_D: bits |= 3'b010;
        CH_M: bits |= 3'b001;
        default: begin
          line_err = 1'b1;
          return '0;
        end
      endcase
    end
    return bits;
  endfunction

  // Unused characters of a field stay zero, so length plus all three characters is the key
  function automatic logic [6:0] comp_of();
    logic [6:0] code;
    logic       known;
    known = 1'b1;
    code  = '0;
    case ({comp_len, comp_buf[0], comp_buf[1], comp_buf[2]})
      {2'd1, "0", 16'h0}: code = 7'h2A;
      {2'd1, "1", 16'h0}: code = 7'h3F;
      {2'd2, "-1", 8'h0}: code = 7'h3A;
      {2'd1, "D", 16'h0}: code = 7'h0C;
      {2'd1, "A", 16'h0}: code = 7'h30;
      {2'd1, "M", 16'h0}: code = 7'h70;
      {2'd2, "!D", 8'h0}: code = 7'h0D;
      {2'd2, "!A", 8'h0}: code = 7'h31;
      {2'd2, "!M", 8'h0}: code = 7'h71;
      {2'd2, "-D", 8'h0}: code = 7'h0F;
      {2'd2, "-A", 8'h0}: code = 7'h33;
      {2'd2, "-M", 8'h0}: code = 7'h73;
      {2'd3, "D+1"}:      code = 7'h1F;
      {2'd3, "A+1"}:      code = 7'h37;
      {2'd3, "M+1"}:      code = 7'h77;
      {2'd3, "D-1"}:      code = 7'h0E;
      {2'd3, "A-1"}:      code = 7'h32;
      {2'd3, "M-1"}:      code = 7'h72;
      {2'd3, "D+A"}:      code = 7'h02;
      {2'd3, "D+M"}:      code = 7'h42;
      {2'd3, "D-A"}:      code = 7'h13;
      {2'd3, "D-M"}:      code = 7'h53;
      {2'd3, "A-D"}:      code = 7'h07;
      {2'd3, "M-D"}:      code = 7'h47;
      {2'd3, "D&A"}:      code = 7'h00;
      {2'd3, "D&M"}:      code = 7'h40;
      {2'd3, "D|A"}:      code = 7'h15;
      {2'd3, "D|M"}:      code = 7'h55;
      default:            known = 1'b0;
    endcase
    if (!known) line_err = 1'b1;
    return code;
  endfunction

  function automatic logic [2:0] jump_of();
    if (jump_len == 2'd3 && jump_buf[0] == CH_J) begin
      case ({jump_buf[1], jump_buf[2]})
        "GT": return 3'd1;
        "EQ": return 3'd2;
        "GE": return 3'd3;
        "LT": return 3'd4;
        "NE": return 3'd5;
        "LE": return 3'd6;
        "MP": return 3'd7;
        default: ;
      endcase
    end
    line_err = 1'b1;
    return '0;
  endfunction

  // Advance the line by one accepted character request; queue a word on the last one
  function automatic void absorb_char(input logic [7:0] c, input logic form, input logic last);
    result_t    r;
    logic [6:0] comp;
    logic [2:0] jmp;
    if (c != CH_LF && c != CH_CR) begin
      if (!form) begin
        if (line_pos != 0) begin
          if (c >= CH_ZERO && c <= CH_NINE) dec_acc = 15'(dec_acc * 10 + (c - CH_ZERO));
          else line_err = 1'b1;
        end
      end else if (c == CH_EQUALS) begin
        if (phase == PH_DEST_COMP && !have_equals && !have_semi) begin
          dest_code   = dest_of();
          have_equals = 1'b1;
          comp_buf    = '{default: '0};
          comp_len    = '0;
          phase       = PH_COMP;
        end else begin
          line_err = 1'b1;
        end
      end else if (c == CH_SEMI) begin
        if (!have_semi) begin
          have_semi = 1'b1;
          phase     = PH_JUMP;
        end else begin
          line_err = 1'b1;
        end
      end else if (phase == PH_JUMP) begin
        // a fourth character poisons the field
        if (jump_len == FIELD_MAX) begin
          jump_buf = '{default: '0};
          line_err = 1'b1;
        end else begin
          jump_buf[jump_len] = c;
          jump_len++;
        end
      end else begin
        if (comp_len == FIELD_MAX) begin
          comp_buf = '{default: '0};
          line_err = 1'b1;
        end else begin
          comp_buf[comp_len] = c;
          comp_len++;
        end
      end
      if (line_pos != 8'hFF) line_pos++;
    end
    if (last) begin
      if (!form) begin
        r.machine_word = line_err ? 16'h0000 : {1'b0, dec_acc};
      end else begin
        comp = comp_of();
        jmp  = have_semi ? jump_of() : 3'b000;
        r.machine_word = {3'b111, comp, dest_code, jmp};
      end
      r.syntax_error = line_err;
      expected_words.push_back(r);
      clear_line();
    end
  endfunction

  // Compare words first, then take in the character of the same edge
  always @(posedge clk) begin
    if (rst) begin
      clear_line();
      expected_words.delete();
    end else begin
      if (words.valid && words.ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("word %h err %b with no line waiting",
                                    words.machine_word, words.syntax_error));
        end else begin
          want = expected_words.pop_front();
          checked++;
          if (want.syntax_error) flagged++;
          if (words.machine_word !== want.machine_word)
            report_mismatch($sformatf("machine_word %h, predicted %h",
                                      words.machine_word, want.machine_word));
          if (words.syntax_error !== want.syntax_error)
            report_mismatch($sformatf("syntax_error %b, predicted %b (word %h)",
                                      words.syntax_error, want.syntax_error,
                                      want.machine_word));
        end
      end
      if (chars.valid && chars.ready)
        absorb_char(chars.char_code, chars.is_compute_form, chars.last_char);
    end
    fail_count    <= fails;
    pending       <= expected_words.size();
    words_checked <= checked;
    error_words   <= flagged;
  end

endmodule

### tb/tb_assembly_line_to_machine_word.sv
`timescale 1ns / 100ps
// Testbench top for the Hack line encoder: clock, reset, line stimulus, word sink and verdict.
module tb_assembly_line_to_machine_word;
  import asml_pkg::*;

  localparam int ITEM_TARGET    = 600;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int HOLDOFF_CYCLES = 80;
  localparam int IDLE_PCT       = 6;

  logic clk;
  logic rst;
  asml_in_if  chars ();
  asml_out_if words ();

  int   fail_count;
  int   pending;
  int   words_checked;
  int   error_words;
  int   cycles;
  int   items_sent;
  int   lines_sent;
  int   holdoff_asked;
  int   holdoff_done;
  logic steady;

  // Line under construction: one character and its form flag per entry
  logic [7:0] line_chars [$];
  logic       line_forms [$];

  string comp_names [28] = '{
    "0", "1", "-1", "D", "A", "M", "!D", "!A", "!M", "-D", "-A", "-M",
    "D+1", "A+1", "M+1", "D-1", "A-1", "M-1", "D+A", "D+M", "D-A", "D-M",
    "A-D", "M-D", "D&A", "D&M", "D|A", "D|M"
  };
  string jump_names [7] = '{"JGT", "JEQ", "JGE", "JLT", "JNE", "JLE", "JMP"};

  assembly_line_to_machine_word dut (
    .clk   (clk),
    .rst   (rst),
    .chars (chars),
    .words (words)
  );

  line_encode_check encode_check (
    .clk           (clk),
    .rst           (rst),
    .chars         (chars),
    .words         (words),
    .fail_count    (fail_count),
    .pending       (pending),
    .words_checked (words_checked),
    .error_words   (error_words)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Word sink: random stalls, a long hold-off on request, none during steady stretches
  initial begin
    words.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holdoff_asked != holdoff_done) begin
        holdoff_done = holdoff_done + 1;
        words.ready <= 1'b0;
        repeat (HOLDOFF_CYCLES - 1) @(posedge clk);
      end else begin
        words.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  function automatic void push_byte(input logic [7:0] c, input logic form);
    line_chars.push_back(c);
    line_forms.push_back(form);
  endfunction

  function automatic void add_text(input string s, input logic form);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], form);
  endfunction

  // dest=comp;jump with optional dest and jump, well-formed but for an occasional four-letter dest
  function automatic void build_compute();
    string letters;
    int    n;
    letters = "ADM";
    if ($urandom_range(1)) begin
      n = ($urandom_range(9) == 0) ? 4 : $urandom_range(1, 3);
      for (int i = 0; i < n; i++) push_byte(letters[$urandom_range(0, 2)], 1'b1);
      push_byte(CH_EQUALS, 1'b1);
    end
    add_text(comp_names[$urandom_range(0, 27)], 1'b1);
    if ($urandom_range(1)) begin
      push_byte(CH_SEMI, 1'b1);
      add_text(jump_names[$urandom_range(0, 6)], 1'b1);
    end
  endfunction

  // Leading character then a decimal value, small, in range or past 2^15
  function automatic void build_address();
    int value;
    case ($urandom_range(0, 2))
      0:       value = $urandom_range(0, 9);
      1:       value = $urandom_range(0, 32767);
      default: value = $urandom_range(0, 99999);
    endcase
    push_byte(($urandom_range(7) == 0) ? 8'($urandom_range(0, 255)) : 8'h40, 1'b0);
    add_text($sformatf("%0d", value), 1'b0);
  endfunction

  // Broken lines: corrupted good lines, line ends, mixed flags, stray separators, noise
  function automatic void build_broken();
    string alphabet;
    int    pos;
    int    n;
    logic  form;
    alphabet = "ADMJ01-+!&|=;GTEQLNP";
    if ($urandom_range(1)) build_compute();
    else build_address();
    pos = $urandom_range(0, line_chars.size() - 1);
    case ($urandom_range(0, 5))
      0: line_chars[pos] = 8'($urandom_range(0, 255));
      1: begin
        if ($urandom_range(1)) begin
          line_chars.insert(pos, $urandom_range(1) ? CH_CR : CH_LF);
          line_forms.insert(pos, line_forms[pos]);
        end else begin
          push_byte($urandom_range(1) ? CH_CR : CH_LF, line_forms[pos]);
        end
      end
      2: line_forms[pos] = !line_forms[pos];
      3: begin
        line_chars.insert(pos, $urandom_range(1) ? CH_EQUALS : CH_SEMI);
        line_forms.insert(pos, 1'b1);
      end
      4: begin
        line_chars.delete();
        line_forms.delete();
        n = $urandom_range(1, 9);
        for (int i = 0; i < n; i++)
          push_byte(alphabet[$urandom_range(0, alphabet.len() - 1)], 1'b1);
      end
      default: begin
        line_chars.delete();
        line_forms.delete();
        n    = $urandom_range(1, 6);
        form = $urandom_range(1);
        for (int i = 0; i < n; i++) push_byte(8'($urandom_range(0, 255)), form);
      end
    endcase
  endfunction

  // Offer one character request, with an occasional idle cycle before it
  task automatic send_char(input logic [7:0] c, input logic form, input logic last);
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      chars.valid <= 1'b0;
      @(posedge clk);
    end
    chars.valid           <= 1'b1;
    chars.char_code       <= c;
    chars.is_compute_form <= form;
    chars.last_char       <= last;
    @(posedge clk);
    while (!chars.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_line();
    for (int i = 0; i < line_chars.size(); i++)
      send_char(line_chars[i], line_forms[i], i == line_chars.size() - 1);
    line_chars.delete();
    line_forms.delete();
    lines_sent++;
  endtask

  // Hold the sender until every predicted word has been taken
  task automatic drain();
    chars.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int r;
    rst                   <= 1'b1;
    steady                <= 1'b0;
    chars.valid           <= 1'b0;
    chars.char_code       <= '0;
    chars.is_compute_form <= 1'b0;
    chars.last_char       <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: lone leading character, wrap past 2^15, bad digit,
    // trailing line end, jump, doubled semicolon
    add_text("@", 1'b0);
    send_line();
    add_text("@65535", 1'b0);
    send_line();
    add_text("@7x", 1'b0);
    send_line();
    add_text("AMD=D|M", 1'b1);
    push_byte(CH_LF, 1'b1);
    send_line();
    add_text("D;JGT", 1'b1);
    send_line();
    add_text("0;;", 1'b1);
    send_line();
    drain();

    // Random lines, mostly well-formed
    while (items_sent < ITEM_TARGET) begin
      r = $urandom_range(99);
      if (r < 45) build_compute();
      else if (r < 70) build_address();
      else build_broken();
      if (lines_sent == 20) holdoff_asked <= holdoff_asked + 1;
      if (lines_sent == 45) drain();
      steady <= (lines_sent >= 60 && lines_sent < 90);
      send_line();
    end

    drain();
    repeat (8) @(posedge clk);
    $display("Sent %0d lines in %0d characters: address and compute forms, all comp and jump",
             lines_sent, items_sent);
    $display("mnemonics, bad fields and separators, mixed flags, line ends; %0d words, %0d flagged",
             words_checked, error_words);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### files.f
sv/asml_pkg.sv
sv/asml_in_if.sv
sv/asml_out_if.sv
sv/asml_in_stage.sv
sv/asml_parser.sv
sv/asml_out_stage.sv
sv/assembly_line_to_machine_word.sv
tb/line_encode_check.sv
tb/tb_assembly_line_to_machine_word.sv
